/* rtl/wep_pkg.sv */
// wep_pkg: shared types, constants and functions of the wep frame encryptor
// no dependencies
package wep_pkg;

  localparam int HeaderBytesDef = 24;
  localparam int MaxKeyBytesDef = 16;
  localparam int CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_ENABLE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_INDEX = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_USED  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_LOWER = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_UPPER = 3'd4;

  localparam logic [31:0] CRC_POLY = 32'hedb88320;

  typedef enum logic [1:0] {
    M_IDLE,
    M_PASS,
    M_HDR,
    M_BODY
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EMIT_IN,
    S_INIT,
    S_KSA0,
    S_KSA1,
    S_KSA2,
    S_KSA3,
    S_HDRX,
    S_KS0,
    S_KS1,
    S_KS2,
    S_KS3,
    S_KS4,
    S_KS5
  } state_t;

  typedef struct packed {
    logic       re;
    logic [7:0] raddr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
  } ram_req_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [23:0] fix_iv(input logic [23:0] iv);
    logic [23:0] r;
    r = iv;
    if (iv[15:8] == 8'hff && iv[23:16] >= 8'd3 && iv[23:16] < 8'd16) begin
      r = iv + 24'h000100;
    end
    return r;
  endfunction

  function automatic logic qualifies(input logic [7:0] fc0);
    return (fc0[3:2] == 2'b10) || (fc0[3:2] == 2'b00 && fc0[7:4] == 4'hb);
  endfunction

endpackage

/* rtl/wep_if.sv */
// wep_if: valid/ready channels of the wep frame encryptor
// depends on nothing
interface wep_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_byte;
  logic        frame_end;
  logic [23:0] random_iv;
  modport source (output valid, frame_byte, frame_end, random_iv, input ready);
  modport sink (input valid, frame_byte, frame_end, random_iv, output ready);
endinterface

interface wep_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_end;
  modport source (output valid, out_byte, out_end, input ready);
  modport sink (input valid, out_byte, out_end, output ready);
endinterface

interface wep_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/wep_frame_encryptor_core.sv */
// wep_frame_encryptor_core: 802.11 wep encapsulation, rc4 keystream and crc-32 icv
// depends on wep_pkg, wep_if and wep_sbox_ram
//
// frame_in takes one frame byte per beat with frame_end on the last byte and
// random_iv sampled on the first byte. frame_out gives the encapsulated frame
// one byte per beat with out_end on its last byte. cfg writes the registers
// enable, key_index, key_bytes_used, key_lower_word, key_upper_word (index 0..4)
// and is always ready.
// at the last header byte the key schedule runs on the permutation memory: it
// fills all 256 entries with their own index, then runs 256 steps that each
// read S[i] and S[j] and write them back swapped, then the three iv bytes and
// the key id are emitted. each payload byte goes through an rc4 step on the
// single read port of the memory (three dependent reads and two writes); the
// icv adds 4 such steps at frame end. one byte is worked on at a time.
// a one-beat output register holds a result while the receiver stalls; the
// sequencer waits until it is free. reset (rst, synchronous) clears the
// control state and registers; the permutation memory is not cleared since
// the key schedule fills it before any read.
module wep_frame_encryptor_core #(
  parameter int HEADER_BYTES  = wep_pkg::HeaderBytesDef,
  parameter int MAX_KEY_BYTES = wep_pkg::MaxKeyBytesDef
) (
  input  logic   clk,
  input  logic   rst,
  wep_in_if.sink   frame_in,
  wep_out_if.source frame_out,
  wep_cfg_if.sink  cfg
);
  import wep_pkg::*;

  localparam logic [4:0] LAST_HDR = 5'(HEADER_BYTES - 1);
  localparam logic [4:0] MAX_KEY  = 5'(MAX_KEY_BYTES);

  logic         enable;
  logic [7:0]   key_index;
  logic [4:0]   key_bytes_used;
  logic [63:0]  key_lower_word;
  logic [63:0]  key_upper_word;

  state_t       st, st_next;
  mode_t        mode, mode_next;
  logic [7:0]   byte_r, byte_r_next;
  logic         end_r, end_r_next;
  logic [4:0]   pos, pos_next;
  logic [23:0]  iv, iv_next;
  logic [7:0]   idx_i, idx_i_next;
  logic [7:0]   idx_j, idx_j_next;
  logic [31:0]  crc, crc_next;
  logic [7:0]   cnt, cnt_next;
  logic [4:0]   kpos, kpos_next;
  logic [4:0]   klen, klen_next;
  logic [127:0] kbits, kbits_next;
  logic [7:0]   kidx, kidx_next;
  logic [1:0]   hcnt, hcnt_next;
  logic [1:0]   icv_cnt, icv_cnt_next;
  logic         icv_on, icv_on_next;
  logic [7:0]   si, si_next;
  logic [7:0]   sj, sj_next;
  logic [7:0]   ks_x, ks_x_next;
  logic         ovalid, ovalid_next;
  logic [7:0]   obyte, obyte_next;
  logic         oend, oend_next;

  ram_req_t     req;
  logic [7:0]   rdata;
  logic         can_emit;
  logic         accept;
  logic [7:0]   key_b;
  logic [7:0]   hdr_b;
  logic [4:0]   kuse;
  logic [31:0]  icv;
  logic [4:0]   ksec;
  logic [7:0]   jsum;

  wep_sbox_ram u_sbox (
    .clk  (clk),
    .req  (req),
    .rdata(rdata)
  );

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      key_index      <= 8'd0;
      key_bytes_used <= 5'd0;
      key_lower_word <= 64'd0;
      key_upper_word <= 64'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLE:    enable         <= cfg.data[0];
        REG_KEY_INDEX: key_index      <= cfg.data[7:0];
        REG_KEY_USED:  key_bytes_used <= cfg.data[4:0];
        REG_KEY_LOWER: key_lower_word <= cfg.data;
        REG_KEY_UPPER: key_upper_word <= cfg.data;
        default: ;
      endcase
    end
  end

  assign frame_in.ready     = (st == S_IDLE);
  assign accept             = frame_in.valid && frame_in.ready;
  assign frame_out.valid    = ovalid;
  assign frame_out.out_byte = obyte;
  assign frame_out.out_end  = oend;
  assign can_emit           = !ovalid || frame_out.ready;
  assign icv                = ~crc;
  assign kuse               = (key_bytes_used > MAX_KEY) ? MAX_KEY : key_bytes_used;
  assign ksec               = kpos - 5'd3;
  assign jsum               = idx_j + rdata + key_b;
  assign hdr_b              = (mode == M_HDR && pos == 5'd1) ? (byte_r | 8'h40) : byte_r;

  always_comb begin
    case (kpos)
      5'd0:    key_b = iv[7:0];
      5'd1:    key_b = iv[15:8];
      5'd2:    key_b = iv[23:16];
      default: key_b = kbits[{ksec[3:0], 3'b000} +: 8];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= S_IDLE;
      mode    <= M_IDLE;
      pos     <= 5'd0;
      iv      <= 24'd0;
      idx_i   <= 8'd0;
      idx_j   <= 8'd0;
      crc     <= '1;
      icv_on  <= 1'b0;
      icv_cnt <= 2'd0;
      hcnt    <= 2'd0;
      cnt     <= 8'd0;
      kpos    <= 5'd0;
      ovalid  <= 1'b0;
    end else begin
      st      <= st_next;
      mode    <= mode_next;
      pos     <= pos_next;
      iv      <= iv_next;
      idx_i   <= idx_i_next;
      idx_j   <= idx_j_next;
      crc     <= crc_next;
      icv_on  <= icv_on_next;
      icv_cnt <= icv_cnt_next;
      hcnt    <= hcnt_next;
      cnt     <= cnt_next;
      kpos    <= kpos_next;
      ovalid  <= ovalid_next;
    end
    byte_r <= byte_r_next;
    end_r  <= end_r_next;
    klen   <= klen_next;
    kbits  <= kbits_next;
    kidx   <= kidx_next;
    si     <= si_next;
    sj     <= sj_next;
    ks_x   <= ks_x_next;
    obyte  <= obyte_next;
    oend   <= oend_next;
  end

  always_comb begin
    st_next      = st;
    mode_next    = mode;
    byte_r_next  = byte_r;
    end_r_next   = end_r;
    pos_next     = pos;
    iv_next      = iv;
    idx_i_next   = idx_i;
    idx_j_next   = idx_j;
    crc_next     = crc;
    cnt_next     = cnt;
    kpos_next    = kpos;
    klen_next    = klen;
    kbits_next   = kbits;
    kidx_next    = kidx;
    hcnt_next    = hcnt;
    icv_cnt_next = icv_cnt;
    icv_on_next  = icv_on;
    si_next      = si;
    sj_next      = sj;
    ks_x_next    = ks_x;
    obyte_next   = obyte;
    oend_next    = oend;
    ovalid_next  = ovalid && !frame_out.ready;
    req          = '0;

    case (st)
      S_IDLE: begin
        if (accept) begin
          byte_r_next = frame_in.frame_byte;
          end_r_next  = frame_in.frame_end;
          if (mode == M_IDLE) begin
            pos_next = 5'd0;
            if (enable && qualifies(frame_in.frame_byte)) begin
              mode_next = M_HDR;
              iv_next   = fix_iv(frame_in.random_iv);
            end else begin
              mode_next = M_PASS;
            end
            st_next = S_EMIT_IN;
          end else if (mode == M_BODY) begin
            crc_next  = crc_byte(crc, frame_in.frame_byte);
            ks_x_next = frame_in.frame_byte;
            st_next   = S_KS0;
          end else begin
            st_next = S_EMIT_IN;
          end
        end
      end
      S_EMIT_IN: begin
        if (can_emit) begin
          ovalid_next = 1'b1;
          obyte_next  = hdr_b;
          if (mode == M_HDR && pos >= LAST_HDR) begin
            oend_next  = 1'b0;
            cnt_next   = 8'd0;
            klen_next  = 5'd3 + kuse;
            kbits_next = {key_upper_word, key_lower_word};
            kidx_next  = key_index;
            st_next    = S_INIT;
          end else begin
            oend_next = end_r;
            if (mode == M_HDR) begin
              pos_next = pos + 5'd1;
            end
            if (end_r) begin
              mode_next = M_IDLE;
              pos_next  = 5'd0;
            end
            st_next = S_IDLE;
          end
        end
      end
      S_INIT: begin
        req.we    = 1'b1;
        req.waddr = cnt;
        req.wdata = cnt;
        cnt_next  = cnt + 8'd1;
        if (cnt == 8'hff) begin
          idx_j_next = 8'd0;
          kpos_next  = 5'd0;
          st_next    = S_KSA0;
        end
      end
      S_KSA0: begin
        req.re    = 1'b1;
        req.raddr = cnt;
        st_next   = S_KSA1;
      end
      S_KSA1: begin
        si_next    = rdata;
        idx_j_next = jsum;
        req.re     = 1'b1;
        req.raddr  = jsum;
        st_next    = S_KSA2;
      end
      S_KSA2: begin
        req.we    = 1'b1;
        req.waddr = cnt;
        req.wdata = rdata;
        st_next   = S_KSA3;
      end
      S_KSA3: begin
        req.we    = 1'b1;
        req.waddr = idx_j;
        req.wdata = si;
        kpos_next = (kpos == klen - 5'd1) ? 5'd0 : kpos + 5'd1;
        cnt_next  = cnt + 8'd1;
        if (cnt == 8'hff) begin
          idx_i_next = 8'd0;
          idx_j_next = 8'd0;
          crc_next   = '1;
          hcnt_next  = 2'd0;
          st_next    = S_HDRX;
        end else begin
          st_next = S_KSA0;
        end
      end
      S_HDRX: begin
        if (can_emit) begin
          ovalid_next = 1'b1;
          oend_next   = 1'b0;
          case (hcnt)
            2'd0:    obyte_next = iv[7:0];
            2'd1:    obyte_next = iv[15:8];
            2'd2:    obyte_next = iv[23:16];
            default: obyte_next = kidx;
          endcase
          hcnt_next = hcnt + 2'd1;
          if (hcnt == 2'd3) begin
            mode_next = M_BODY;
            if (end_r) begin
              icv_on_next  = 1'b1;
              icv_cnt_next = 2'd0;
              ks_x_next    = icv[7:0];
              st_next      = S_KS0;
            end else begin
              st_next = S_IDLE;
            end
          end
        end
      end
      S_KS0: begin
        idx_i_next = idx_i + 8'd1;
        req.re     = 1'b1;
        req.raddr  = idx_i + 8'd1;
        st_next    = S_KS1;
      end
      S_KS1: begin
        si_next    = rdata;
        idx_j_next = idx_j + rdata;
        req.re     = 1'b1;
        req.raddr  = idx_j + rdata;
        st_next    = S_KS2;
      end
      S_KS2: begin
        sj_next   = rdata;
        req.we    = 1'b1;
        req.waddr = idx_i;
        req.wdata = rdata;
        st_next   = S_KS3;
      end
      S_KS3: begin
        req.we    = 1'b1;
        req.waddr = idx_j;
        req.wdata = si;
        st_next   = S_KS4;
      end
      S_KS4: begin
        req.re    = 1'b1;
        req.raddr = si + sj;
        st_next   = S_KS5;
      end
      S_KS5: begin
        if (can_emit) begin
          ovalid_next = 1'b1;
          obyte_next  = ks_x ^ rdata;
          oend_next   = icv_on && icv_cnt == 2'd3;
          if (icv_on) begin
            if (icv_cnt == 2'd3) begin
              icv_on_next = 1'b0;
              mode_next   = M_IDLE;
              pos_next    = 5'd0;
              st_next     = S_IDLE;
            end else begin
              icv_cnt_next = icv_cnt + 2'd1;
              ks_x_next    = icv[{icv_cnt + 2'd1, 3'b000} +: 8];
              st_next      = S_KS0;
            end
          end else if (end_r) begin
            icv_on_next  = 1'b1;
            icv_cnt_next = 2'd0;
            ks_x_next    = icv[7:0];
            st_next      = S_KS0;
          end else begin
            st_next = S_IDLE;
          end
        end
      end
      default: st_next = S_IDLE;
    endcase
  end

  a_no_same_addr_rw: assert property (@(posedge clk) disable iff (rst)
    !(req.we && req.re && req.waddr == req.raddr))
    else $error("permutation memory read and written at one address");

  a_sched_in_hdr: assert property (@(posedge clk) disable iff (rst)
    (st == S_INIT || st == S_KSA0 || st == S_KSA3) |-> mode == M_HDR)
    else $error("key schedule outside a protected header");

  a_icv_last_end: assert property (@(posedge clk) disable iff (rst)
    (st == S_KS5 && can_emit && icv_on && icv_cnt == 2'd3) |=> (ovalid && oend))
    else $error("last icv beat without frame end");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (icv_on || st == S_INIT) |-> !frame_in.ready)
    else $error("input taken during key schedule or icv");
endmodule

/* rtl/wep_sbox_ram.sv */
// wep_sbox_ram: 256 x 8 rc4 permutation memory, one write and one registered read
// depends on wep_pkg
module wep_sbox_ram (
  input  logic              clk,
  input  wep_pkg::ram_req_t req,
  output logic [7:0]        rdata
);
  import wep_pkg::*;

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule
